FILE: design/oaat_pkg.sv
`default_nettype none

package oaat_pkg;

    localparam int HASH_WIDTH_DEFAULT = 32;
    localparam int CHAR_WIDTH         = 16;
    localparam int BUCKET_WIDTH       = 32;

    // shift amounts of the per-unit mix and of the final avalanche
    localparam int MIX_SHL   = 10;
    localparam int MIX_SHR   = 6;
    localparam int AVAL_SHL1 = 3;
    localparam int AVAL_SHR  = 11;
    localparam int AVAL_SHL2 = 15;

    // commands from the controller to the datapath
    typedef struct packed {
        logic mix;        // fold the accepted code unit into the accumulator
        logic aval_first; // avalanche: add <<3, xor >>11
        logic aval_second;// avalanche: add <<15
        logic div_start;  // clear the partial remainder
        logic div_step;   // one restoring division step
        logic load_out;   // capture the remainder into the output register
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/oaat_datapath.sv
`default_nettype none

module oaat_datapath #(
    parameter int HASH_WIDTH = oaat_pkg::HASH_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire oaat_pkg::cmd_t                    cmd,
    input  wire logic [oaat_pkg::CHAR_WIDTH-1:0]   char_code,
    input  wire logic                              cfg_valid,
    input  wire logic [oaat_pkg::BUCKET_WIDTH-1:0] cfg_data,
    output logic      [oaat_pkg::BUCKET_WIDTH-1:0] bucket_index
);

    localparam int BW = oaat_pkg::BUCKET_WIDTH;
    localparam int RW = oaat_pkg::BUCKET_WIDTH + 1;

    logic [HASH_WIDTH-1:0] acc_reg, acc_next;
    logic [BW-1:0]         rem_reg, rem_next;
    logic [BW-1:0]         bucket_count_reg;
    logic [BW-1:0]         out_data_reg;

    logic [RW-1:0] divisor;
    logic [RW-1:0] rem_shift;

    // a zero bucket count stands for 2^32
    assign divisor   = {(bucket_count_reg == '0), bucket_count_reg};
    assign rem_shift = {rem_reg, acc_reg[HASH_WIDTH-1]};

    always_comb
    begin
        logic [HASH_WIDTH-1:0] t;
        t        = '0;
        acc_next = acc_reg;
        rem_next = rem_reg;
        if (cmd.mix)
        begin
            t        = acc_reg + {{(HASH_WIDTH-oaat_pkg::CHAR_WIDTH){1'b0}}, char_code};
            t        = t + (t << oaat_pkg::MIX_SHL);
            acc_next = t ^ (t >> oaat_pkg::MIX_SHR);
        end
        else if (cmd.aval_first)
        begin
            t        = acc_reg + (acc_reg << oaat_pkg::AVAL_SHL1);
            acc_next = t ^ (t >> oaat_pkg::AVAL_SHR);
        end
        else if (cmd.aval_second)
        begin
            acc_next = acc_reg + (acc_reg << oaat_pkg::AVAL_SHL2);
        end
        else if (cmd.div_step)
        begin
            // dividend shifts out of the accumulator, leaving it cleared
            acc_next = acc_reg << 1;
            if (rem_shift >= divisor)
                rem_next = BW'(rem_shift - divisor);
            else
                rem_next = rem_shift[BW-1:0];
        end
        if (cmd.div_start)
            rem_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg          <= '0;
            bucket_count_reg <= BW'(1);
        end
        else
        begin
            acc_reg <= acc_next;
            if (cfg_valid)
                bucket_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.load_out)
            out_data_reg <= rem_reg;
    end

    assign bucket_index = out_data_reg;

endmodule

`default_nettype wire

FILE: design/oaat_ctrl.sv
`default_nettype none

module oaat_ctrl #(
    parameter int HASH_WIDTH = oaat_pkg::HASH_WIDTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           in_no_char,
    input  wire logic           in_last,
    output logic                out_valid,
    input  wire logic           out_ready,
    output oaat_pkg::cmd_t      cmd
);

    localparam int CNT_W = $clog2(HASH_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_WIDTH - 1);

    localparam logic [2:0] ST_ACCUM = 3'd0;
    localparam logic [2:0] ST_AVAL1 = 3'd1;
    localparam logic [2:0] ST_AVAL2 = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign in_ready  = (state_reg == ST_ACCUM);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                if (accept)
                begin
                    cmd.mix = !in_no_char;
                    if (in_last)
                        state_next = ST_AVAL1;
                end
            end
            ST_AVAL1:
            begin
                cmd.aval_first = 1'b1;
                state_next     = ST_AVAL2;
            end
            ST_AVAL2:
            begin
                cmd.aval_second = 1'b1;
                cmd.div_start   = 1'b1;
                cnt_next        = '0;
                state_next      = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a pending transaction");

    a_last_starts_final: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (state_reg == ST_AVAL1))
        else $error("last unit did not start the avalanche");

    a_div_starts_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_AVAL2) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("division did not start at step zero");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg != CNT_LAST) |=> (state_reg == ST_DIV))
        else $error("division left early");

endmodule

`default_nettype wire

FILE: design/one_at_a_time_bucket_hash_unit.sv
// Non-final code units: one per cycle while the input is ready, no result.
// Last unit: result valid after two avalanche steps, HASH_WIDTH restoring division
// steps of one bit each and a load into the output register, which waits while a
// previous result is still pending. The input stalls from the last unit of a string
// until its result is loaded, while the bit-serial modulo unit runs.
// Reset: accumulator cleared, bucket_count set to 1, no result pending.
`default_nettype none

module one_at_a_time_bucket_hash_unit #(
    parameter int HASH_WIDTH = oaat_pkg::HASH_WIDTH_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [oaat_pkg::CHAR_WIDTH-1:0]   s_tdata,  // char_code
    input  wire logic                              s_tuser,  // no_char
    input  wire logic                              s_tlast,  // last
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [oaat_pkg::BUCKET_WIDTH-1:0] m_tdata,  // bucket_index
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [oaat_pkg::BUCKET_WIDTH-1:0] cfg_data  // bucket_count
);

    oaat_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    oaat_ctrl #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_no_char (s_tuser),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .cmd        (cmd)
    );

    oaat_datapath #(
        .HASH_WIDTH (HASH_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .char_code    (s_tdata),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .bucket_index (m_tdata)
    );

endmodule

`default_nettype wire
